### hdl/spt_pkg.sv
package spt_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF    = 16;
    localparam int ID_BITS_DEF  = 16;
    localparam int POS_BITS_DEF = 16;

    // Fixed port widths
    localparam int OPCODE_W = 2;
    localparam int IN_ID_W  = 16;
    localparam int IN_POS_W = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_POS_EMPTY   = 3'd1,
        ST_TABLE_EMPTY = 3'd2,
        ST_FULL        = 3'd3,
        ST_ABSENT      = 3'd4
    } t_status;

    // Per-transaction control broadcast to every cell
    typedef struct packed {
        logic ins_en;   // insert in progress, table not full
        logic rem_en;   // remove in progress, identifier present
    } t_cell_ctl;

endpackage

### hdl/sorted_position_table.sv
// sorted_position_table
//
// Holds up to DEPTH cars (identifier, lane position) in ascending position
// order, one entry per cell of a linear cell chain.
//
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. busy is always low: every command finishes in the cycle it is
// taken, so one command can be issued every clock.
//   insert : entry goes in front of the first stored car at or beyond its
//            position; cells past the insert point take their left neighbor.
//   remove : first entry with the identifier is dropped; cells from the hit
//            onward take their right neighbor.
//   query  : reports whether any stored car sits at the position.
// Result channel: o_done pulses for one cycle, the cycle after the command,
// with o_status and o_entry_count (count after the command). Throughput is
// one command per cycle; the compare path set by the cell chain (identifier
// match ripples cell to cell) is the critical path.
// The receiver cannot stall: a result is present for exactly one cycle.
// Reset clears the entry count and the result strobe; cell contents are not
// cleared, entries at or above the count are never observed.
module sorted_position_table #(
    parameter int DEPTH    = spt_pkg::DEPTH_DEF,
    parameter int ID_BITS  = spt_pkg::ID_BITS_DEF,
    parameter int POS_BITS = spt_pkg::POS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spt_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [spt_pkg::IN_ID_W-1:0]   i_car_id,
    input  logic [spt_pkg::IN_POS_W-1:0]  i_lane_position,
    output logic                          o_done,
    output logic [spt_pkg::STATUS_W-1:0]  o_status,
    output logic [spt_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 accept;
    spt_pkg::t_opcode     op;
    logic [ID_BITS+spt_pkg::IN_ID_W-1:0]   id_ext;
    logic [POS_BITS+spt_pkg::IN_POS_W-1:0] pos_ext;
    logic [ID_BITS-1:0]   cmd_id;
    logic [POS_BITS-1:0]  cmd_pos;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_done;
    spt_pkg::t_status     r_status;
    spt_pkg::t_status     n_status;
    logic [CNT_W+spt_pkg::COUNT_W-1:0] count_ext;

    logic                 full;
    logic                 empty;
    spt_pkg::t_cell_ctl   ctl;

    // Chain wiring
    logic [ID_BITS-1:0]   cell_id  [DEPTH];
    logic [POS_BITS-1:0]  cell_pos [DEPTH];
    logic [DEPTH-1:0]     cell_valid;
    logic [DEPTH-1:0]     cell_ge;
    logic [DEPTH-1:0]     cell_hit;
    logic [DEPTH-1:0]     cell_pos_hit;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = spt_pkg::t_opcode'(i_opcode);

    // Keep only the low ID_BITS / POS_BITS of the command fields
    assign id_ext  = {{ID_BITS{1'b0}}, i_car_id};
    assign pos_ext = {{POS_BITS{1'b0}}, i_lane_position};
    assign cmd_id  = id_ext[ID_BITS-1:0];
    assign cmd_pos = pos_ext[POS_BITS-1:0];

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    assign ctl.ins_en = accept && (op == spt_pkg::OP_INSERT) && !full;
    // Last cell's hit output says the identifier is somewhere in the table
    assign ctl.rem_en = accept && (op == spt_pkg::OP_REMOVE) && cell_hit[DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [ID_BITS-1:0]  left_id;
            logic [POS_BITS-1:0] left_pos;
            logic                left_ge;
            logic [ID_BITS-1:0]  right_id;
            logic [POS_BITS-1:0] right_pos;
            logic                hit_in;

            assign cell_valid[g] = (r_count > CNT_W'(g));

            if (g == 0) begin : g_head
                assign left_id  = cell_id[g];
                assign left_pos = cell_pos[g];
                assign left_ge  = 1'b0;
                assign hit_in   = 1'b0;
            end else begin : g_body
                assign left_id  = cell_id[g-1];
                assign left_pos = cell_pos[g-1];
                assign left_ge  = cell_ge[g-1];
                assign hit_in   = cell_hit[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_id  = cell_id[g];
                assign right_pos = cell_pos[g];
            end else begin : g_mid
                assign right_id  = cell_id[g+1];
                assign right_pos = cell_pos[g+1];
            end

            spt_cell #(
                .ID_BITS  (ID_BITS),
                .POS_BITS (POS_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_valid     (cell_valid[g]),
                .i_new_id    (cmd_id),
                .i_new_pos   (cmd_pos),
                .i_left_id   (left_id),
                .i_left_pos  (left_pos),
                .i_left_ge   (left_ge),
                .i_right_id  (right_id),
                .i_right_pos (right_pos),
                .i_hit_in    (hit_in),
                .o_id        (cell_id[g]),
                .o_pos       (cell_pos[g]),
                .o_ge        (cell_ge[g]),
                .o_hit_out   (cell_hit[g]),
                .o_pos_hit   (cell_pos_hit[g])
            );
        end
    endgenerate

    // Status and next count
    always_comb begin
        n_count  = r_count;
        n_status = spt_pkg::ST_OK;
        case (op)
            spt_pkg::OP_INSERT: begin
                if (full) begin
                    n_status = spt_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            spt_pkg::OP_REMOVE: begin
                if (cell_hit[DEPTH-1]) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = spt_pkg::ST_ABSENT;
                end
            end
            spt_pkg::OP_QUERY: begin
                if (empty) begin
                    n_status = spt_pkg::ST_TABLE_EMPTY;
                end else if (!(|cell_pos_hit)) begin
                    n_status = spt_pkg::ST_POS_EMPTY;
                end
            end
            default: begin
                n_status = spt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status <= n_status;
        end
    end

    // Count reported masked to the result field width
    assign count_ext     = {{spt_pkg::COUNT_W{1'b0}}, r_count};
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_count = count_ext[spt_pkg::COUNT_W-1:0];

    // Count never exceeds the number of cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A successful insert grows the table by exactly one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins_en |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the table");

    // Remove of an absent identifier leaves the count alone and flags it
    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (op == spt_pkg::OP_REMOVE) && !cell_hit[DEPTH-1])
        |=> ($stable(r_count) && (r_status == spt_pkg::ST_ABSENT)))
        else $error("absent remove changed the table");

    // The first two valid cells stay in ascending position order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > CNT_W'(1)) |-> (cell_pos[1] >= cell_pos[0]))
        else $error("head cells out of order");

endmodule

### hdl/spt_cell.sv
module spt_cell #(
    parameter int ID_BITS  = spt_pkg::ID_BITS_DEF,
    parameter int POS_BITS = spt_pkg::POS_BITS_DEF
) (
    input  logic                i_clk,
    input  spt_pkg::t_cell_ctl  i_ctl,
    input  logic                i_valid,
    input  logic [ID_BITS-1:0]  i_new_id,
    input  logic [POS_BITS-1:0] i_new_pos,
    input  logic [ID_BITS-1:0]  i_left_id,
    input  logic [POS_BITS-1:0] i_left_pos,
    input  logic                i_left_ge,
    input  logic [ID_BITS-1:0]  i_right_id,
    input  logic [POS_BITS-1:0] i_right_pos,
    input  logic                i_hit_in,
    output logic [ID_BITS-1:0]  o_id,
    output logic [POS_BITS-1:0] o_pos,
    output logic                o_ge,
    output logic                o_hit_out,
    output logic                o_pos_hit
);

    logic [ID_BITS-1:0]  r_id;
    logic [POS_BITS-1:0] r_pos;
    logic [ID_BITS-1:0]  n_id;
    logic [POS_BITS-1:0] n_pos;

    // Insert point: empty slot or stored position not below the new one
    assign o_ge      = !i_valid || (r_pos >= i_new_pos);
    // First identifier match and everything after it shifts left
    assign o_hit_out = i_hit_in || (i_valid && (r_id == i_new_id));
    assign o_pos_hit = i_valid && (r_pos == i_new_pos);
    assign o_id      = r_id;
    assign o_pos     = r_pos;

    always_comb begin
        n_id  = r_id;
        n_pos = r_pos;
        if (i_ctl.ins_en) begin
            if (i_left_ge) begin
                n_id  = i_left_id;
                n_pos = i_left_pos;
            end else if (o_ge) begin
                n_id  = i_new_id;
                n_pos = i_new_pos;
            end
        end else if (i_ctl.rem_en && o_hit_out) begin
            n_id  = i_right_id;
            n_pos = i_right_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_pos <= n_pos;
    end

endmodule
